FILE: sv/afir_pkg.sv
// ----------------------------------------------------------------------------
// afir_pkg
// Types and protocol constants shared by the find-information responder.
// ----------------------------------------------------------------------------
package afir_pkg;

  localparam logic [7:0] OP_ERROR_RSP       = 8'h01;
  localparam logic [7:0] OP_FIND_INFO_REQ   = 8'h04;
  localparam logic [7:0] OP_FIND_INFO_RSP   = 8'h05;
  localparam logic [7:0] ERR_INVALID_HANDLE = 8'h01;
  localparam logic [7:0] ERR_NOT_FOUND      = 8'h0A;
  localparam logic [7:0] FMT_SHORT          = 8'h01;
  localparam logic [7:0] FMT_LONG           = 8'h02;
  localparam int unsigned LEN_SHORT         = 4;
  localparam int unsigned LEN_LONG          = 18;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_FIND = 1'b1;

  typedef struct packed {
    logic        is_long;
    logic [63:0] uuid_low;
    logic [63:0] uuid_high;
  } entry_data_t;

endpackage

FILE: sv/att_find_information_responder.sv
// ----------------------------------------------------------------------------
// att_find_information_responder
// Attribute table with an ATT Find Information responder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): func 0 loads an attribute entry, func 1
// is a find-information request over [range_start, range_end]. Items are
// handled one at a time: in_stall is high from the cycle after acceptance
// until the item is finished.
// Result channel (out_valid/out_stall): one response byte per transaction,
// resp_last high on the final byte of each response.
// Valid flags are registers; handles and UUID data sit in two synchronous
// memories with registered read outputs.
// A load sweeps the handle memory for a matching or else a free slot, then
// writes the entry there if such a slot was found.
// A bad range goes to the error state, which sends the error response one
// byte per cycle while the receiver does not stall. Otherwise each search
// sweeps the handle memory for the lowest valid handle in range, reads that
// entry's data and sends its bytes; the final byte of each entry is held
// until it is known whether that byte ends the response.
// Reset clears all valid flags at once; the memories need no clearing.
// When the receiver stalls, the current byte is held and the walk pauses.
// ----------------------------------------------------------------------------
module att_find_information_responder #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MTU_BYTES     = 23
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_attr_handle,
  input  logic        in_uuid_is_long,
  input  logic [63:0] in_uuid_low_bytes,
  input  logic [63:0] in_uuid_high_bytes,
  input  logic [15:0] in_range_start,
  input  logic [15:0] in_range_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_resp_byte,
  output logic        out_resp_last
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 2);
  localparam int TW = $clog2(MTU_BYTES + 1);

  localparam logic [CW-1:0] SCAN_N   = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] SCAN_END = CW'(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LSCAN = 3'd1;
  localparam logic [2:0] S_FSCAN = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [15:0] hnd_mem [TABLE_ENTRIES];
  afir_pkg::entry_data_t mem [TABLE_ENTRIES];
  afir_pkg::entry_data_t rd_q;

  logic [15:0] h_r, lo_r, end_r;
  logic        long_r;
  logic [63:0] ulo_r, uhi_r;
  logic [CW-1:0] scan_r;
  logic [IW-1:0] si;
  logic        sq_r, vq_r;
  logic [IW-1:0] iq_r;
  logic [15:0] hq_r;
  logic        found_r, free_f_r, match_f_r;
  logic [IW-1:0] best_r, free_r, match_r, slot;
  logic        wr_en;
  logic [15:0] bh_r;
  logic        first_r, first_long_r;
  logic [TW-1:0] total_r;
  logic [4:0]  bidx_r;
  logic [15:0] cur_h_r;
  logic [2:0]  eidx_r;
  logic [7:0]  err_code_r;
  logic        ov_r, ov_nxt;
  logic        pend_r;
  logic [7:0]  ob_r;
  logic        ol_r;

  assign si = scan_r[IW-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_resp_byte = ob_r;
  assign out_resp_last = ol_r;

  assign slot = match_f_r ? match_r : free_r;
  assign wr_en = (state_r == S_LSCAN) && (scan_r == SCAN_END) && (match_f_r || free_f_r);

  logic take;
  assign take = in_valid && !in_stall;
  logic ofree;
  assign ofree = !ov_r || !out_stall;

  logic [TW:0] tot_len;
  assign tot_len = {1'b0, total_r} + (first_long_r ? (TW+1)'(afir_pkg::LEN_LONG)
                                                   : (TW+1)'(afir_pkg::LEN_SHORT));

  logic [4:0] nbytes;
  assign nbytes = first_long_r ? 5'd18 : 5'd4;

  // next entry differs in UUID length or would overrun the MTU
  logic walk_end;
  assign walk_end = (bidx_r == 5'd0) && (rd_q.is_long != first_long_r ||
                    tot_len > (TW+1)'(MTU_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ov_r <= 1'b0;
      sq_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      sq_r <= (state_r == S_LSCAN || state_r == S_FSCAN) && (scan_r < SCAN_N);
      vq_r <= valid_r[si];
      iq_r <= si;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            h_r <= in_attr_handle;
            long_r <= in_uuid_is_long;
            ulo_r <= in_uuid_low_bytes;
            uhi_r <= in_uuid_high_bytes;
            lo_r <= in_range_start;
            end_r <= in_range_end;
            scan_r <= '0;
            found_r <= 1'b0;
            free_f_r <= 1'b0;
            match_f_r <= 1'b0;
            first_r <= 1'b1;
            pend_r <= 1'b0;
            total_r <= TW'(2);
            eidx_r <= '0;
          end
        end
        S_LSCAN: begin
          if (sq_r && vq_r && hq_r == h_r && !match_f_r) begin
            match_f_r <= 1'b1; match_r <= iq_r;
          end
          if (sq_r && !vq_r && !free_f_r) begin
            free_f_r <= 1'b1; free_r <= iq_r;
          end
          if (scan_r != SCAN_END) scan_r <= scan_r + 1'b1;
          else if (wr_en) valid_r[slot] <= 1'b1;
        end
        S_FSCAN: begin
          if (sq_r && vq_r && hq_r >= lo_r && hq_r <= end_r &&
              (!found_r || hq_r < bh_r)) begin
            found_r <= 1'b1; best_r <= iq_r; bh_r <= hq_r;
          end
          if (scan_r != SCAN_END) begin
            scan_r <= scan_r + 1'b1;
          end else if (!found_r) begin
            if (first_r) begin
              err_code_r <= afir_pkg::ERR_NOT_FOUND;
            end else begin
              ol_r <= 1'b1;
              pend_r <= 1'b0;
            end
          end
        end
        S_READ: begin
          cur_h_r <= bh_r;
          bidx_r <= '0;
          if (first_r) begin
            first_long_r <= rd_q.is_long;
            total_r <= TW'(2);
          end
        end
        S_EMIT: begin
          if (ofree) begin
            if (first_r && eidx_r < 3'd2) begin
              ol_r <= 1'b0;
              ob_r <= (eidx_r == 3'd0) ? afir_pkg::OP_FIND_INFO_RSP :
                      (first_long_r ? afir_pkg::FMT_LONG : afir_pkg::FMT_SHORT);
              eidx_r <= eidx_r + 1'b1;
            end else if (walk_end) begin
              // held byte closes the response
              ol_r <= 1'b1;
              pend_r <= 1'b0;
            end else if (pend_r) begin
              ol_r <= 1'b0;
              pend_r <= 1'b0;
            end else begin
              priority case (1'b1)
                bidx_r == 5'd0: ob_r <= cur_h_r[7:0];
                bidx_r == 5'd1: ob_r <= cur_h_r[15:8];
                bidx_r < 5'd10: ob_r <= rd_q.uuid_low[8*(bidx_r-5'd2) +: 8];
                default:        ob_r <= rd_q.uuid_high[8*(bidx_r-5'd10) +: 8];
              endcase
              bidx_r <= bidx_r + 1'b1;
              if (bidx_r == nbytes - 1'b1) begin
                ol_r <= (cur_h_r >= end_r);
                pend_r <= (cur_h_r < end_r);
                total_r <= tot_len[TW-1:0];
                first_r <= 1'b0;
                lo_r <= cur_h_r + 16'd1;
                scan_r <= '0;
                found_r <= 1'b0;
              end else begin
                ol_r <= 1'b0;
              end
            end
          end
        end
        S_ERR: begin
          if (ofree) begin
            ol_r <= (eidx_r == 3'd4);
            unique case (eidx_r)
              3'd0: ob_r <= afir_pkg::OP_ERROR_RSP;
              3'd1: ob_r <= afir_pkg::OP_FIND_INFO_REQ;
              3'd2: ob_r <= lo_r[7:0];
              3'd3: ob_r <= lo_r[15:8];
              default: ob_r <= err_code_r;
            endcase
            eidx_r <= eidx_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (state_r == S_IDLE && take && in_func == afir_pkg::FUNC_FIND &&
          (in_range_start == 16'd0 || in_range_start > in_range_end))
        err_code_r <= afir_pkg::ERR_INVALID_HANDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hnd_mem[slot] <= h_r;
      mem[slot] <= '{long_r, ulo_r, uhi_r};
    end
    hq_r <= hnd_mem[si];
    rd_q <= mem[best_r];
  end

  always_comb begin
    ov_nxt = ov_r && out_stall;
    if (state_r == S_FSCAN && scan_r == SCAN_END && !found_r && !first_r) begin
      ov_nxt = 1'b1;
    end else if (state_r == S_ERR && ofree) begin
      ov_nxt = 1'b1;
    end else if (state_r == S_EMIT && ofree) begin
      if (!(first_r && eidx_r < 3'd2) && !walk_end && !pend_r &&
          bidx_r == nbytes - 1'b1)
        ov_nxt = (cur_h_r >= end_r);
      else
        ov_nxt = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) begin
        if (in_func == afir_pkg::FUNC_LOAD) state_nxt = S_LSCAN;
        else if (in_range_start == 16'd0 || in_range_start > in_range_end)
          state_nxt = S_ERR;
        else state_nxt = S_FSCAN;
      end
      S_LSCAN: if (scan_r == SCAN_END) state_nxt = S_IDLE;
      S_FSCAN: if (scan_r == SCAN_END)
        state_nxt = found_r ? S_READ : (first_r ? S_ERR : S_IDLE);
      S_READ: state_nxt = S_EMIT;
      S_EMIT: if (ofree) begin
        if (first_r && eidx_r < 3'd2) state_nxt = S_EMIT;
        else if (walk_end) state_nxt = S_IDLE;
        else if (pend_r) state_nxt = S_EMIT;
        else if (bidx_r == nbytes - 1'b1)
          state_nxt = (cur_h_r >= end_r) ? S_IDLE : S_FSCAN;
      end
      S_ERR: if (ofree && eidx_r == 3'd4) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
